[rtl/three_class_queue_arbiter_macros.svh]
// assertion macros for the three-class queue arbiter
// used by rtl/three_class_queue_arbiter.sv, no other dependencies
`ifndef THREE_CLASS_QUEUE_ARBITER_MACROS_SVH
`define THREE_CLASS_QUEUE_ARBITER_MACROS_SVH

// same-cycle implication, disabled during reset
`define TCQA_ASSERT_NOW(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("tcqa assertion failed");

// next-cycle implication, disabled during reset
`define TCQA_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("tcqa assertion failed");

`endif

[rtl/tcqa_pkg.sv]
// shared types and constants for the three-class queue arbiter
// no dependencies
`timescale 1ns / 1ps

package tcqa_pkg;

  localparam int ID_W = 16;
  localparam int CLS_W = 2;
  localparam int CMD_W = 2;
  localparam int SRV_W = 3;
  localparam int STREAK_W = 4;
  localparam int THR_W = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 5;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_SERVERS = 5;
  localparam int DEF_SENIOR_SERVERS = 2;

  localparam logic [CMD_W-1:0] CMD_ARRIVE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SERVE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PROMOTE = 2'd2;

  localparam logic [CLS_W-1:0] CLS_CRIT = 2'd0;
  localparam logic [CLS_W-1:0] CLS_SER  = 2'd1;
  localparam logic [CLS_W-1:0] CLS_NORM = 2'd2;
  localparam logic [CLS_W-1:0] CLS_NONE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_PROMOTE_THRESHOLD   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_STREAK_LIMIT = 1'd1;

  localparam logic [THR_W-1:0]    THRESHOLD_RESET = 5'd5;
  localparam logic [STREAK_W-1:0] LIMIT_RESET     = 4'd3;
  localparam logic [STREAK_W-1:0] STREAK_MAX      = 4'd15;
  localparam logic [ID_W-1:0]     ID_RESET        = 16'd1;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [CLS_W-1:0] request_class;
    logic [SRV_W-1:0] server_index;
  } in_item_t;

  typedef struct packed {
    logic             done_res;
    logic [ID_W-1:0]  item_id;
    logic [CLS_W-1:0] item_class;
    logic             queue_full;
  } out_item_t;

endpackage

[rtl/three_class_queue_arbiter.sv]
// three-class queue arbiter: critical, serious and normal id queues with
// per-server grant priority, streak limits and serious-to-critical promotion
// depends on tcqa_pkg and three_class_queue_arbiter_macros.svh
// an accepted beat is held in the input register, and its result in the result register
// throughput: one beat per cycle unless the output stalls; all queue work sits between them
// reset: queue heads, counts and server streaks clear, id counter goes to 1,
// threshold to 5 and streak limit to 3; queue storage is not cleared
`timescale 1ns / 1ps
`include "three_class_queue_arbiter_macros.svh"

module three_class_queue_arbiter #(
  parameter int QUEUE_DEPTH    = tcqa_pkg::DEF_QUEUE_DEPTH,
  parameter int SERVERS        = tcqa_pkg::DEF_SERVERS,
  parameter int SENIOR_SERVERS = tcqa_pkg::DEF_SENIOR_SERVERS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tcqa_pkg::in_item_t             in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tcqa_pkg::out_item_t            out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tcqa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcqa_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int CMPW = (CW > tcqa_pkg::THR_W) ? CW : tcqa_pkg::THR_W;
  localparam int NQ = 3;

  logic [tcqa_pkg::ID_W-1:0]     fifo_mem [NQ][QUEUE_DEPTH];
  logic [AW-1:0]                 head [NQ];
  logic [AW-1:0]                 head_next [NQ];
  logic [CW-1:0]                 count [NQ];
  logic [CW-1:0]                 count_next [NQ];
  logic [tcqa_pkg::STREAK_W-1:0] streak [SERVERS];
  logic [tcqa_pkg::STREAK_W-1:0] streak_next [SERVERS];
  logic [tcqa_pkg::ID_W-1:0]     next_id;
  logic [tcqa_pkg::ID_W-1:0]     next_id_next;
  logic [tcqa_pkg::THR_W-1:0]    promote_threshold;
  logic [tcqa_pkg::STREAK_W-1:0] normal_streak_limit;

  logic                          s1_valid;
  tcqa_pkg::in_item_t            s1_item;
  logic                          stall;
  logic                          fire;
  tcqa_pkg::out_item_t           result;

  logic [AW-1:0]                 tail [NQ];
  logic [tcqa_pkg::ID_W-1:0]     head_data [NQ];
  logic                          wr_en [NQ];
  logic [tcqa_pkg::ID_W-1:0]     wr_data [NQ];

  // handshake and pipeline control
  assign stall     = out_valid && !out_ready;
  assign in_ready  = !s1_valid || !stall;
  assign fire      = s1_valid && !stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (!stall) begin
        s1_valid <= 1'b0;
      end
      if (!stall) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
    if (fire) begin
      out_item <= result;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      promote_threshold <= tcqa_pkg::THRESHOLD_RESET;
      normal_streak_limit <= tcqa_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tcqa_pkg::REG_PROMOTE_THRESHOLD: begin
          promote_threshold <= cfg_data;
        end
        tcqa_pkg::REG_NORMAL_STREAK_LIMIT: begin
          normal_streak_limit <= cfg_data[tcqa_pkg::STREAK_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // per-queue tail and head word
  always_comb begin
    logic [CW:0] sum;
    for (int k = 0; k < NQ; k++) begin
      sum = (CW+1)'(head[k]) + (CW+1)'(count[k]);
      if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
        sum = sum - (CW+1)'(QUEUE_DEPTH);
      end
      tail[k] = AW'(sum);
      head_data[k] = fifo_mem[k][head[k]];
    end
  end

  // one item's work
  always_comb begin
    logic [tcqa_pkg::STREAK_W-1:0] cur_streak;
    logic                          srv_ok;
    logic                          senior;
    logic                          pick_ok;
    logic [tcqa_pkg::CLS_W-1:0]    pick;
    int unsigned                   cls;

    cur_streak = '0;
    pick_ok = 1'b0;
    pick = tcqa_pkg::CLS_CRIT;
    cls = 32'(s1_item.request_class);
    srv_ok = 32'(s1_item.server_index) < SERVERS;
    senior = 32'(s1_item.server_index) < SENIOR_SERVERS;

    result = '0;
    next_id_next = next_id;
    for (int k = 0; k < NQ; k++) begin
      head_next[k] = head[k];
      count_next[k] = count[k];
      wr_en[k] = 1'b0;
      wr_data[k] = next_id;
    end
    for (int i = 0; i < SERVERS; i++) begin
      streak_next[i] = streak[i];
      if (32'(s1_item.server_index) == i) begin
        cur_streak = streak[i];
      end
    end

    unique case (s1_item.command)
      tcqa_pkg::CMD_ARRIVE: begin
        if (s1_item.request_class != tcqa_pkg::CLS_NONE) begin
          next_id_next = next_id + 1'b1;
          result.item_id = next_id;
          result.item_class = s1_item.request_class;
          if (count[cls] == CW'(QUEUE_DEPTH)) begin
            result.queue_full = 1'b1;
          end else begin
            result.done_res = 1'b1;
            wr_en[cls] = 1'b1;
            count_next[cls] = count[cls] + 1'b1;
          end
        end
      end
      tcqa_pkg::CMD_SERVE: begin
        if (srv_ok) begin
          priority if (cur_streak >= normal_streak_limit && count[1] != '0) begin
            pick_ok = 1'b1;
            pick = tcqa_pkg::CLS_SER;
          end else if (senior && count[0] != '0) begin
            pick_ok = 1'b1;
            pick = tcqa_pkg::CLS_CRIT;
          end else if (count[1] != '0) begin
            pick_ok = 1'b1;
            pick = tcqa_pkg::CLS_SER;
          end else if (count[2] != '0) begin
            pick_ok = 1'b1;
            pick = tcqa_pkg::CLS_NORM;
          end else begin
            pick_ok = 1'b0;
          end
          if (pick_ok) begin
            result.done_res = 1'b1;
            result.item_class = pick;
            result.item_id = head_data[32'(pick)];
            head_next[32'(pick)] = (head[32'(pick)] == AW'(QUEUE_DEPTH - 1)) ? '0
                                 : head[32'(pick)] + 1'b1;
            count_next[32'(pick)] = count[32'(pick)] - 1'b1;
            for (int i = 0; i < SERVERS; i++) begin
              if (32'(s1_item.server_index) == i) begin
                if (pick != tcqa_pkg::CLS_NORM) begin
                  streak_next[i] = '0;
                end else if (streak[i] != tcqa_pkg::STREAK_MAX) begin
                  streak_next[i] = streak[i] + 1'b1;
                end
              end
            end
          end
        end
      end
      tcqa_pkg::CMD_PROMOTE: begin
        if (count[1] != '0 && CMPW'(count[1]) >= CMPW'(promote_threshold)
            && count[0] != CW'(QUEUE_DEPTH)) begin
          result.done_res = 1'b1;
          result.item_class = tcqa_pkg::CLS_CRIT;
          result.item_id = head_data[1];
          head_next[1] = (head[1] == AW'(QUEUE_DEPTH - 1)) ? '0 : head[1] + 1'b1;
          count_next[1] = count[1] - 1'b1;
          wr_en[0] = 1'b1;
          wr_data[0] = head_data[1];
          count_next[0] = count[0] + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // queue state and storage
  always_ff @(posedge clk) begin
    if (rst) begin
      next_id <= tcqa_pkg::ID_RESET;
      for (int k = 0; k < NQ; k++) begin
        head[k] <= '0;
        count[k] <= '0;
      end
      for (int i = 0; i < SERVERS; i++) begin
        streak[i] <= '0;
      end
    end else if (fire) begin
      next_id <= next_id_next;
      for (int k = 0; k < NQ; k++) begin
        head[k] <= head_next[k];
        count[k] <= count_next[k];
      end
      for (int i = 0; i < SERVERS; i++) begin
        streak[i] <= streak_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NQ; k++) begin
      if (fire && wr_en[k]) begin
        fifo_mem[k][tail[k]] <= wr_data[k];
      end
    end
  end

  `TCQA_ASSERT_NOW(a_idle_result_zero, clk, rst,
    out_valid && !out_item.done_res && !out_item.queue_full,
    out_item.item_id == '0 && out_item.item_class == tcqa_pkg::CLS_CRIT)
  `TCQA_ASSERT_NOW(a_full_not_done, clk, rst,
    out_valid && out_item.queue_full, !out_item.done_res)
  `TCQA_ASSERT_NOW(a_counts_bounded, clk, rst, 1'b1,
    count[0] <= CW'(QUEUE_DEPTH) && count[1] <= CW'(QUEUE_DEPTH)
    && count[2] <= CW'(QUEUE_DEPTH))
  `TCQA_ASSERT_NEXT(a_stage_held_on_stall, clk, rst,
    s1_valid && stall, s1_valid && $stable(s1_item))

endmodule

[test/testbench.sv]
// self-checking testbench for the three-class queue arbiter: predicts each
// result beat from the accepted commands and compares it field by field
// depends on tcqa_pkg and rtl/three_class_queue_arbiter.sv
`timescale 1ns / 1ps

module testbench;
  import tcqa_pkg::*;

  localparam int LONG_HOLD = 300;

  class arbiter_scoreboard;
    logic [ID_W-1:0]     crit_ids[$];
    logic [ID_W-1:0]     ser_ids[$];
    logic [ID_W-1:0]     norm_ids[$];
    logic [STREAK_W-1:0] streak[DEF_SERVERS];
    logic [THR_W-1:0]    threshold;
    logic [STREAK_W-1:0] streak_limit;
    logic [ID_W-1:0]     next_id;
    out_item_t           outcomes[$];
    int                  mismatches;

    function new();
      foreach (streak[i]) streak[i] = '0;
      threshold = THRESHOLD_RESET;
      streak_limit = LIMIT_RESET;
      next_id = ID_RESET;
      mismatches = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_PROMOTE_THRESHOLD) threshold = val[THR_W-1:0];
      else if (idx == REG_NORMAL_STREAK_LIMIT) streak_limit = val[STREAK_W-1:0];
    endfunction

    function void note_command(in_item_t it);
      out_item_t        r;
      logic [CLS_W-1:0] pick;
      int               count;
      r = '0;
      case (it.command)
        CMD_ARRIVE: begin
          if (it.request_class != CLS_NONE) begin
            r.item_id = next_id;
            r.item_class = it.request_class;
            next_id++;
            case (it.request_class)
              CLS_CRIT: count = crit_ids.size();
              CLS_SER:  count = ser_ids.size();
              default:  count = norm_ids.size();
            endcase
            if (count >= DEF_QUEUE_DEPTH) begin
              r.queue_full = 1'b1;
            end else begin
              r.done_res = 1'b1;
              case (it.request_class)
                CLS_CRIT: crit_ids.push_back(r.item_id);
                CLS_SER:  ser_ids.push_back(r.item_id);
                default:  norm_ids.push_back(r.item_id);
              endcase
            end
          end
        end
        CMD_SERVE: begin
          if (it.server_index < DEF_SERVERS) begin
            pick = CLS_NONE;
            if (streak[it.server_index] >= streak_limit && ser_ids.size() > 0) pick = CLS_SER;
            else if (it.server_index < DEF_SENIOR_SERVERS && crit_ids.size() > 0) pick = CLS_CRIT;
            else if (ser_ids.size() > 0) pick = CLS_SER;
            else if (norm_ids.size() > 0) pick = CLS_NORM;
            case (pick)
              CLS_CRIT: r.item_id = crit_ids.pop_front();
              CLS_SER:  r.item_id = ser_ids.pop_front();
              CLS_NORM: r.item_id = norm_ids.pop_front();
              default:  ;
            endcase
            if (pick != CLS_NONE) begin
              r.done_res = 1'b1;
              r.item_class = pick;
              if (pick == CLS_NORM) begin
                if (streak[it.server_index] < STREAK_MAX) streak[it.server_index]++;
              end else begin
                streak[it.server_index] = '0;
              end
            end
          end
        end
        CMD_PROMOTE: begin
          if (ser_ids.size() > 0 && ser_ids.size() >= threshold &&
              crit_ids.size() < DEF_QUEUE_DEPTH) begin
            r.item_id = ser_ids.pop_front();
            crit_ids.push_back(r.item_id);
            r.item_class = CLS_CRIT;
            r.done_res = 1'b1;
          end
        end
        default: ;
      endcase
      outcomes.push_back(r);
    endfunction

    function void check_outcome(out_item_t got);
      out_item_t want;
      if (outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: done=%0d id=%0d class=%0d full=%0d",
                   got.done_res, got.item_id, got.item_class, got.queue_full);
        return;
      end
      want = outcomes.pop_front();
      if (got.done_res !== want.done_res || got.item_id !== want.item_id ||
          got.item_class !== want.item_class || got.queue_full !== want.queue_full) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected done=%0d id=%0d class=%0d full=%0d",
                   want.done_res, want.item_id, want.item_class, want.queue_full,
                   ", got done=%0d id=%0d class=%0d full=%0d",
                   got.done_res, got.item_id, got.item_class, got.queue_full);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  arbiter_scoreboard sb;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int holds_asked = 0;

  three_class_queue_arbiter u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_command(in_item);
      if (out_valid && out_ready) sb.check_outcome(out_item);
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin : receiver
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        holds_served = holds_asked;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic in_item_t make_beat(logic [CMD_W-1:0] cmd, logic [CLS_W-1:0] cls,
                                         logic [SRV_W-1:0] srv);
    in_item_t it;
    it.command = cmd;
    it.request_class = cls;
    it.server_index = srv;
    return it;
  endfunction

  function automatic in_item_t random_command(int arrive_pct, int promote_pct,
                                              logic [CLS_W-1:0] focus);
    in_item_t it;
    int       roll;
    it.command = CMD_W'($urandom_range(3));
    it.request_class = CLS_W'($urandom_range(3));
    it.server_index = SRV_W'($urandom_range(7));
    if ($urandom_range(99) < 6) return it;
    roll = $urandom_range(99);
    if (roll < arrive_pct) begin
      it.command = CMD_ARRIVE;
      if (focus != CLS_NONE && $urandom_range(99) < 70) it.request_class = focus;
      else it.request_class = CLS_W'($urandom_range(2));
    end else if (roll < arrive_pct + promote_pct) begin
      it.command = CMD_PROMOTE;
    end else begin
      it.command = CMD_SERVE;
      it.server_index = SRV_W'($urandom_range(DEF_SERVERS - 1));
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] lim);
    cfg_valid <= 1'b1;
    cfg_index <= REG_PROMOTE_THRESHOLD;
    cfg_data <= thr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(REG_PROMOTE_THRESHOLD, thr);
    cfg_index <= REG_NORMAL_STREAK_LIMIT;
    cfg_data <= lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(REG_NORMAL_STREAK_LIMIT, lim);
    cfg_valid <= 1'b0;
  endtask

  // every 20 commands a burst picks at random a filling, mixed or draining command mix
  task automatic run_phase(input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] lim,
                           input int send_pct, input int recv_pct, input int n);
    int               arrive_pct;
    int               promote_pct;
    logic [CLS_W-1:0] focus;
    arrive_pct = 50;
    promote_pct = 10;
    focus = CLS_NONE;
    drain();
    configure(thr, lim);
    send_idle_pct = send_pct;
    stall_pct <= recv_pct;
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) begin
        case ($urandom_range(2))
          0:       arrive_pct = 85;
          1:       arrive_pct = 45;
          default: arrive_pct = 15;
        endcase
        promote_pct = $urandom_range(5, 25);
        focus = CLS_W'($urandom_range(3));
      end
      send_item(random_command(arrive_pct, promote_pct, focus));
    end
  endtask

  initial begin : stimulus
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty queues, ignored commands and out-of-range servers
    send_item(make_beat(CMD_SERVE, CLS_CRIT, 3'd0));
    send_item(make_beat(CMD_PROMOTE, CLS_NONE, 3'd7));
    send_item(make_beat(CMD_ARRIVE, CLS_CRIT, 3'd7));
    send_item(make_beat(CMD_ARRIVE, CLS_SER, 3'd0));
    send_item(make_beat(CMD_ARRIVE, CLS_NORM, 3'd5));
    send_item(make_beat(CMD_ARRIVE, CLS_NONE, 3'd2));
    send_item(make_beat(2'd3, CLS_NONE, 3'd7));
    send_item(make_beat(CMD_SERVE, CLS_NONE, 3'd5));
    send_item(make_beat(CMD_SERVE, CLS_CRIT, 3'd6));
    send_item(make_beat(CMD_SERVE, CLS_SER, 3'd7));
    // junior skips critical, senior takes it, then normal
    send_item(make_beat(CMD_SERVE, CLS_CRIT, 3'd4));
    send_item(make_beat(CMD_SERVE, CLS_CRIT, 3'd0));
    send_item(make_beat(CMD_SERVE, CLS_CRIT, 3'd3));
    // normal streak on a senior server forces serious ahead of critical
    send_item(make_beat(CMD_ARRIVE, CLS_NORM, 3'd0));
    send_item(make_beat(CMD_ARRIVE, CLS_NORM, 3'd0));
    send_item(make_beat(CMD_ARRIVE, CLS_NORM, 3'd0));
    send_item(make_beat(CMD_SERVE, CLS_CRIT, 3'd1));
    send_item(make_beat(CMD_SERVE, CLS_CRIT, 3'd1));
    send_item(make_beat(CMD_SERVE, CLS_CRIT, 3'd1));
    send_item(make_beat(CMD_ARRIVE, CLS_CRIT, 3'd0));
    send_item(make_beat(CMD_ARRIVE, CLS_SER, 3'd0));
    send_item(make_beat(CMD_SERVE, CLS_CRIT, 3'd1));
    send_item(make_beat(CMD_SERVE, CLS_CRIT, 3'd1));

    run_phase(5'd5, 5'd3, 0, 0, 110);
    run_phase(5'd0, 5'd0, 48, 0, 110);
    run_phase(5'd16, 5'd15, 0, 48, 110);
    run_phase(5'd1, 5'd1, 36, 36, 110);
    run_phase(5'd31, 5'd18, 48, 48, 110);
    run_phase(5'd3, 5'd31, 36, 36, 110);

    // receiver holds off while commands keep coming, then sender waits it out
    drain();
    configure(5'd4, 5'd2);
    send_idle_pct = 0;
    stall_pct <= 0;
    holds_asked <= holds_asked + 1;
    repeat (40) send_item(random_command(60, 10, CLS_NONE));

    drain();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.outcomes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
